/* src/rmbs_pkg.sv */
package rmbs_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 10;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic do_clear;
    logic do_append;
    logic ld_search;
    logic step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_zero;
    logic cont;
    logic out_busy;
  } sts_t;

endpackage

/* src/rightmost_match_binary_search.sv */
// flow: append and clear complete in the idle state; a search loads its range, probes the
// element memory until the range closes, then loads the result in the check state
// throughput: one item at a time; each search probe is one read of the element memory,
// with the next address formed in the same cycle as the compare
// reset: rst is synchronous, active high; it empties the store and drops any result

module rightmost_match_binary_search #(
  parameter int DEPTH = rmbs_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmbs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rmbs_pkg::out_item_t out_item
);

  import rmbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rmbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (in_item.action),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  rmbs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* src/rmbs_ram.sv */
module rmbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/rmbs_ctrl.sv */
module rmbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    action,
  input  rmbs_pkg::sts_t sts,
  output rmbs_pkg::cmd_t cmd,
  output logic          in_stall
);

  import rmbs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && action == ACT_SEARCH) begin
          state_next = sts.fill_zero ? ST_CHECK : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!sts.cont) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.do_clear  = in_valid && action == ACT_CLEAR;
        cmd.do_append = in_valid && action == ACT_APPEND;
        cmd.ld_search = in_valid && action == ACT_SEARCH;
      end
      ST_PROBE: begin
        cmd.step = 1'b1;
      end
      ST_CHECK: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* src/rmbs_dp.sv */
module rmbs_dp #(
  parameter int DEPTH = rmbs_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rmbs_pkg::in_item_t    in_item,
  input  rmbs_pkg::cmd_t        cmd,
  output rmbs_pkg::sts_t        sts,
  input  logic                  out_stall,
  output logic                  out_valid,
  output rmbs_pkg::out_item_t   out_item
);

  import rmbs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      fill;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      mid;
  logic [VALUE_W-1:0] target;

  logic [CW-1:0]      lo_next;
  logic [CW-1:0]      hi_next;
  logic [CW-1:0]      mid_next;
  logic [CW-1:0]      hi_m1;
  logic [CW-1:0]      hi_dec;
  logic [CW-1:0]      fill_half;
  logic               le;
  logic               not_full;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;
  logic               hit;
  logic [AW+POS_W-1:0] pos_ext;

  rmbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[AW-1:0]),
    .wdata (in_item.value),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign not_full = fill != CW'(DEPTH);
  assign ram_we   = cmd.do_append && not_full;
  assign ram_re   = cmd.ld_search || cmd.step;

  assign fill_half = fill >> 1;

  // probe result of the element read at mid
  assign le       = $signed(rdata) <= $signed(target);
  assign lo_next  = le ? mid + CW'(1) : lo;
  assign hi_next  = le ? hi : mid;
  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);
  assign hi_m1    = hi_next - CW'(1);

  always_comb begin
    if (cmd.step) begin
      // once the range closes, fetch the element just left of hi
      raddr = sts.cont ? mid_next[AW-1:0] : hi_m1[AW-1:0];
    end else begin
      raddr = fill_half[AW-1:0];
    end
  end

  assign sts.fill_zero = fill == '0;
  assign sts.cont      = lo_next < hi_next;
  assign sts.out_busy  = out_valid && out_stall;

  assign hit     = (hi != '0) && (rdata == target);
  assign hi_dec  = hi - CW'(1);
  assign pos_ext = {{POS_W{1'b0}}, hi_dec[AW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.do_clear) begin
      fill <= '0;
    end else if (ram_we) begin
      fill <= fill + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_search) begin
      lo     <= '0;
      hi     <= fill;
      mid    <= fill_half;
      target <= in_item.value;
    end else if (cmd.step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.found    <= hit;
      out_item.position <= hit ? pos_ext[POS_W-1:0] : '0;
    end
  end

endmodule

/* src/rmbs_chk.sv */
module rmbs_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input rmbs_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input rmbs_pkg::out_item_t out_item
);

  import rmbs_pkg::*;

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.found |-> out_item.position == '0)
    else $error("position not zero on a miss");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.action == ACT_SEARCH |=> in_stall)
    else $error("input taken while a search runs");

  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a search in flight");

endmodule

bind rightmost_match_binary_search rmbs_chk u_chk (.*);

/* tb/tb.sv */
module tb;
  import rmbs_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         act;
    logic [VALUE_W-1:0] val;
    logic               fixed_ans;
    logic               fnd;
    logic [POS_W-1:0]   pos;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  rightmost_match_binary_search dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the store and its fill count
  logic signed [VALUE_W-1:0] shadow_elems [DEPTH];
  int        shadow_fill = 0;
  out_item_t answers_due [$];
  out_item_t want;
  int        errors = 0;
  int        cycles = 0;
  int        fed = 0;
  bit        calm = 1'b0;

  // empty store, extremes, duplicates, ignored code, clear, unsorted store
  plan_row_t plan [0:24] = '{
    {ACT_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 10'd0},
    {ACT_SEARCH, 32'h8000_0000, 1'b1, 1'b0, 10'd0},
    {ACT_UNUSED, 32'h0000_0005, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h0000_0007, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h0000_0007, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h0000_0007, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0},
    {ACT_SEARCH, 32'h8000_0000, 1'b1, 1'b1, 10'd1},
    {ACT_SEARCH, 32'h7FFF_FFFF, 1'b1, 1'b1, 10'd7},
    {ACT_SEARCH, 32'h0000_0007, 1'b0, 1'b0, 10'd0},
    {ACT_SEARCH, 32'h0000_0003, 1'b0, 1'b0, 10'd0},
    {ACT_SEARCH, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
    {ACT_UNUSED, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
    {ACT_SEARCH, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
    {ACT_CLEAR,  32'h0000_0000, 1'b0, 1'b0, 10'd0},
    {ACT_SEARCH, 32'h0000_0007, 1'b1, 1'b0, 10'd0},
    {ACT_APPEND, 32'h0000_0005, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h0000_0001, 1'b0, 1'b0, 10'd0},
    {ACT_APPEND, 32'h0000_0009, 1'b0, 1'b0, 10'd0},
    {ACT_SEARCH, 32'h0000_0005, 1'b0, 1'b0, 10'd0},
    {ACT_SEARCH, 32'h0000_0001, 1'b0, 1'b0, 10'd0}
  };

  // half-open search that moves right on equal or smaller, then checks the last hit
  function automatic out_item_t rightmost_search(logic signed [VALUE_W-1:0] tgt);
    int lo;
    int hi;
    int mid;
    out_item_t ans;
    lo = 0;
    hi = shadow_fill;
    ans = '0;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (shadow_elems[mid] <= tgt) lo = mid + 1;
      else hi = mid;
    end
    if (hi > 0 && shadow_elems[hi-1] == tgt) begin
      ans.found = 1'b1;
      ans.position = POS_W'(hi - 1);
    end
    return ans;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_target();
    int r;
    logic signed [VALUE_W-1:0] t;
    r = $urandom_range(99);
    if (shadow_fill == 0 || r < 15) begin
      t = $urandom;
    end else if (r < 22) begin
      t = (r < 19) ? VMIN : VMAX;
    end else begin
      if (r < 30) t = shadow_elems[shadow_fill-1];
      else if (r < 36) t = shadow_elems[0];
      else t = shadow_elems[$urandom_range(0, shadow_fill-1)];
      // near misses
      if (r >= 80) t = (r < 90) ? t + 1 : t - 1;
    end
    return t;
  endfunction

  task automatic send(logic [1:0] act, logic signed [VALUE_W-1:0] val,
                      bit has_fixed, out_item_t fixed_ans);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item.action = act;
    in_item.value = val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    case (act)
      ACT_CLEAR: shadow_fill = 0;
      ACT_APPEND: begin
        if (shadow_fill < DEPTH) begin
          shadow_elems[shadow_fill] = val;
          shadow_fill++;
        end
      end
      ACT_SEARCH: answers_due.push_back(has_fixed ? fixed_ans : rightmost_search(val));
      default: ;
    endcase
    if (act != ACT_UNUSED) fed++;
  endtask

  task automatic run_phase(int n_app, int n_srch, bit scrambled, bit do_clear);
    longint cur;
    longint stepmax;
    logic signed [VALUE_W-1:0] val;
    int k;
    if (do_clear) send(ACT_CLEAR, $urandom, 1'b0, '0);
    case ($urandom_range(2))
      0: cur = longint'($signed($urandom));
      1: cur = longint'(VMIN) + longint'($urandom_range(0, 50));
      default: cur = longint'($urandom_range(0, 60)) - 30;
    endcase
    if ($urandom_range(1) == 0 || n_app == 0) begin
      stepmax = 4;
    end else begin
      stepmax = ((longint'(VMAX) - cur) / n_app) * 2;
      if (stepmax > 64'hFFFF_FFFF) stepmax = 64'hFFFF_FFFF;
    end
    for (k = 0; k < n_app; k++) begin
      if (scrambled) begin
        val = $urandom;
      end else begin
        // a skipped step leaves a duplicate
        if (k > 0 && $urandom_range(3) != 0)
          cur += longint'($urandom_range(0, 32'(stepmax)));
        if (cur > longint'(VMAX)) cur = longint'(VMAX);
        val = cur[VALUE_W-1:0];
      end
      if ($urandom_range(99) < 6) send(ACT_UNUSED, $urandom, 1'b0, '0);
      if ($urandom_range(99) < 5) send(ACT_SEARCH, pick_target(), 1'b0, '0);
      send(ACT_APPEND, val, 1'b0, '0);
    end
    for (k = 0; k < n_srch; k++) begin
      if ($urandom_range(99) < 6) send(ACT_UNUSED, $urandom, 1'b0, '0);
      send(ACT_SEARCH, pick_target(), 1'b0, '0);
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !calm && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, found=%0b position=%0d", $time,
                 out_item.found, out_item.position);
      end else begin
        want = answers_due.pop_front();
        if (out_item.found !== want.found) begin
          errors++;
          $display("%0t: found expected %0b got %0b", $time, want.found, out_item.found);
        end
        if (out_item.position !== want.position) begin
          errors++;
          $display("%0t: position expected %0d got %0d", $time, want.position,
                   out_item.position);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int i;
    int ph;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < 25; i++)
      send(plan[i].act, plan[i].val, plan[i].fixed_ans, out_item_t'({plan[i].fnd, plan[i].pos}));

    fed = 0;
    ph = 0;
    while (fed < RANDOM_ITEMS) begin
      calm = (ph >= 8 && ph < 14);
      if (ph == 5) begin
        // hold off until the block has drained
        @(negedge clk);
        in_valid = 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
      end
      run_phase(($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40),
                $urandom_range(1, 12), $urandom_range(19) == 0, $urandom_range(9) != 0);
      ph++;
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
